// ===== src/gb3_pkg.sv =====
package gb3_pkg;

    localparam int PIX_W      = 8;
    localparam int COL_OUT_W  = 11;
    localparam int ROW_W      = 12;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int FWIDTH_W   = 12;
    localparam int FHEIGHT_W  = 13;
    localparam int SUM_W      = 12;
    localparam int MAX_HEIGHT = 4096;

    localparam int FRAME_WIDTH_RESET  = 640;
    localparam int FRAME_HEIGHT_RESET = 480;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    // per-pixel tag carried alongside the line store read
    typedef struct packed {
        logic [COL_OUT_W-1:0] center_col;
        logic [ROW_W-1:0]     center_row;
        logic                 emit;
        logic                 last;
    } tag_t;

endpackage

// ===== src/gb3_ram.sv =====
module gb3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/gb3_scan.sv =====
// Raster position counters and frame size registers.
module gb3_scan #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [gb3_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gb3_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           advance,
    output logic [$clog2(MAX_WIDTH)-1:0]   rd_addr,
    output gb3_pkg::tag_t                  tag
);

    localparam int CNT_W = $clog2(MAX_WIDTH);
    localparam int CMP_W = (CNT_W + 1 > gb3_pkg::FWIDTH_W) ? CNT_W + 1 : gb3_pkg::FWIDTH_W;
    localparam int RESET_LAST_COL = (gb3_pkg::FRAME_WIDTH_RESET > MAX_WIDTH) ?
                                    MAX_WIDTH - 1 : gb3_pkg::FRAME_WIDTH_RESET - 1;

    logic [CNT_W-1:0]           col_reg, col_next;
    logic [gb3_pkg::ROW_W-1:0]  row_reg, row_next;
    logic [CNT_W-1:0]           last_col_reg, last_col_next;
    logic [gb3_pkg::ROW_W-1:0]  last_row_reg, last_row_next;
    logic [CMP_W-1:0]           fw;
    logic [CMP_W-1:0]           fw_last;
    logic [gb3_pkg::FHEIGHT_W-1:0] fh;
    logic [gb3_pkg::FHEIGHT_W-1:0] fh_last;
    logic [CNT_W-1:0]           col_m1;
    logic [CNT_W+gb3_pkg::COL_OUT_W-1:0] col_m1_ext;

    // clamp sizes once, at write time
    always_comb begin
        fw = CMP_W'(cfg_wdata[gb3_pkg::FWIDTH_W-1:0]);
        if (fw < CMP_W'(3)) begin
            fw_last = CMP_W'(2);
        end else if (fw > CMP_W'(MAX_WIDTH)) begin
            fw_last = CMP_W'(MAX_WIDTH - 1);
        end else begin
            fw_last = fw - CMP_W'(1);
        end
        fh = cfg_wdata[gb3_pkg::FHEIGHT_W-1:0];
        if (fh < gb3_pkg::FHEIGHT_W'(3)) begin
            fh_last = gb3_pkg::FHEIGHT_W'(2);
        end else if (fh > gb3_pkg::FHEIGHT_W'(gb3_pkg::MAX_HEIGHT)) begin
            fh_last = gb3_pkg::FHEIGHT_W'(gb3_pkg::MAX_HEIGHT - 1);
        end else begin
            fh_last = fh - gb3_pkg::FHEIGHT_W'(1);
        end
    end

    always_comb begin
        last_col_next = last_col_reg;
        last_row_next = last_row_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                gb3_pkg::REG_FRAME_WIDTH:  last_col_next = fw_last[CNT_W-1:0];
                gb3_pkg::REG_FRAME_HEIGHT: last_row_next = fh_last[gb3_pkg::ROW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (advance) begin
            if (col_reg >= last_col_reg) begin
                col_next = '0;
                row_next = (row_reg >= last_row_reg) ? '0 : row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            last_col_reg <= CNT_W'(RESET_LAST_COL);
            last_row_reg <= gb3_pkg::ROW_W'(gb3_pkg::FRAME_HEIGHT_RESET - 1);
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            last_col_reg <= last_col_next;
            last_row_reg <= last_row_next;
        end
    end

    assign col_m1     = col_reg - 1'b1;
    assign col_m1_ext = {{gb3_pkg::COL_OUT_W{1'b0}}, col_m1};

    assign rd_addr        = col_reg;
    assign tag.center_col = col_m1_ext[gb3_pkg::COL_OUT_W-1:0];
    assign tag.center_row = row_reg - 1'b1;
    assign tag.emit       = (row_reg >= gb3_pkg::ROW_W'(2)) && (col_reg >= CNT_W'(2));
    assign tag.last       = (col_reg == last_col_reg) && (row_reg == last_row_reg);

endmodule

// ===== src/gb3_window.sv =====
// 3x3 window: two columns of history plus the incoming column, 1-2-1 kernel.
module gb3_window (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      advance,
    input  logic [gb3_pkg::PIX_W-1:0] top,
    input  logic [gb3_pkg::PIX_W-1:0] mid,
    input  logic [gb3_pkg::PIX_W-1:0] bot,
    output logic [gb3_pkg::PIX_W-1:0] blurred
);

    localparam int SW = gb3_pkg::SUM_W;

    // [0..1] top c-2,c-1; [2..3] middle; [4..5] bottom
    logic [gb3_pkg::PIX_W-1:0] win_reg [6];
    logic [SW-1:0] row_top, row_mid, row_bot, sum;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= '0;
            end
        end else if (advance) begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= top;
            win_reg[2] <= win_reg[3];
            win_reg[3] <= mid;
            win_reg[4] <= win_reg[5];
            win_reg[5] <= bot;
        end
    end

    // horizontal 1-2-1 per row, then vertical 1-2-1
    assign row_top = SW'(win_reg[0]) + SW'({win_reg[1], 1'b0}) + SW'(top);
    assign row_mid = SW'(win_reg[2]) + SW'({win_reg[3], 1'b0}) + SW'(mid);
    assign row_bot = SW'(win_reg[4]) + SW'({win_reg[5], 1'b0}) + SW'(bot);
    assign sum     = row_top + {row_mid[SW-2:0], 1'b0} + row_bot;

    assign blurred = sum[SW-1:4];

endmodule

// ===== src/gaussian_blur_3x3_core.sv =====
// 3x3 Gaussian blur (1-2-1 x 1-2-1, sum >> 4) on a raster stream of 8-bit
// pixels. One pixel transaction is taken every clock while s_tready is high; a
// result passes the read stage and the output register, and leaves only for interior
// pixels (rows and columns 1 .. size-2), so border pixels produce nothing.
// The two previous rows live in one simple dual-port RAM of MAX_WIDTH words
// of 16 bits (upper and middle line packed together): it is read at the
// column of the incoming pixel when the pixel is accepted and written back
// (middle moves up, new pixel becomes middle) one stage later. Consecutive
// pixels never share a column, so the read-modify-write needs no forwarding.
// The RAM is never cleared: the first two rows after reset fill it before any
// window uses it. Frame width and height are taken through cfg_wr_en /
// cfg_index / cfg_wdata (index 0 width, index 1 height), clamped to
// 3..MAX_WIDTH and 3..4096, and must only be changed while the core is idle.
// The output register holds a stalled result while the next pixel is already
// in the read stage; back-pressure reaches s_tready only when both are full.
module gaussian_blur_3x3_core #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration
    input  logic                           cfg_wr_en,
    input  logic [gb3_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gb3_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // pixel input
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,  // [7:0] pixel_in
    // blurred output
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [31:0]                    m_tdata,  // [7:0] blurred_value,
                                                     // [18:8] center_col,
                                                     // [30:19] center_row, [31] zero
    output logic                           m_tlast   // frame_last
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int PW = gb3_pkg::PIX_W;

    logic          s_acc;
    logic [AW-1:0] rd_addr;
    gb3_pkg::tag_t tag;

    // read stage: RAM output is valid here
    logic          s1_valid_reg, s1_valid_next;
    gb3_pkg::tag_t s1_tag_reg;
    logic [AW-1:0] s1_addr_reg;
    logic [PW-1:0] s1_pix_reg;
    logic          s1_adv;

    logic [2*PW-1:0] ram_rdata;
    logic [PW-1:0]   line_top, line_mid;
    logic [PW-1:0]   blurred;

    // output register
    logic          m_valid_reg, m_valid_next;
    logic [PW-1:0] m_value_reg;
    logic [gb3_pkg::COL_OUT_W-1:0] m_col_reg;
    logic [gb3_pkg::ROW_W-1:0]     m_row_reg;
    logic          m_last_reg;

    assign s1_adv   = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign s_acc    = s_tvalid && s_tready;

    gb3_scan #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .advance   (s_acc),
        .rd_addr   (rd_addr),
        .tag       (tag)
    );

    // line stores: {upper, middle}
    gb3_ram #(
        .WIDTH (2 * PW),
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .aclk  (aclk),
        .we    (s1_adv),
        .waddr (s1_addr_reg),
        .wdata ({line_mid, s1_pix_reg}),
        .re    (s_acc),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    assign line_top = ram_rdata[2*PW-1:PW];
    assign line_mid = ram_rdata[PW-1:0];

    gb3_window u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (s1_adv),
        .top     (line_top),
        .mid     (line_mid),
        .bot     (s1_pix_reg),
        .blurred (blurred)
    );

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_acc) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (s1_adv) begin
            m_valid_next = s1_tag_reg.emit;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            s1_tag_reg  <= tag;
            s1_addr_reg <= rd_addr;
            s1_pix_reg  <= s_tdata[PW-1:0];
        end
        if (s1_adv) begin
            m_value_reg <= blurred;
            m_col_reg   <= s1_tag_reg.center_col;
            m_row_reg   <= s1_tag_reg.center_row;
            m_last_reg  <= s1_tag_reg.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_row_reg, m_col_reg, m_value_reg};
    assign m_tlast  = m_last_reg;

`ifndef NO_ASSERTIONS
    // back-pressure only when both the read stage and the output are full
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (s1_valid_reg && m_valid_reg && !m_tready))
        else $error("s_tready low without a full pipeline");

    // write-back never hits the column being read in the same cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_adv && s_acc) |-> (s1_addr_reg != rd_addr))
        else $error("line store read and write collide");

    // a border pixel leaving the read stage never raises a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_adv && !s1_tag_reg.emit) |=> !m_valid_reg)
        else $error("result produced for a border pixel");

    // results never sit on the border
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_col_reg != '0 && m_row_reg != '0))
        else $error("result with border coordinates");
`endif

endmodule
